// ===== rtl/core/tbp_pkg.sv =====
`timescale 1ns / 1ps

package tbp_pkg;

	// Global history length limit and config register width
	localparam int unsigned HIST_MAX   = 11;
	localparam int unsigned HIST_CFG_W = 4;
	localparam int unsigned CTR_W      = 2;

	localparam logic [HIST_CFG_W-1:0] HIST_BITS_RESET = 4'd11;

	// 2-bit saturating counter codes
	localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'b00;
	localparam logic [CTR_W-1:0] CTR_WEAK_NT   = 2'b01;
	localparam logic [CTR_W-1:0] CTR_WEAK_T    = 2'b10;
	localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'b11;

	// Chooser reset: strongly prefer gshare
	localparam logic [CTR_W-1:0] CHOOSE_STRONG_GSHARE = CTR_STRONG_NT;

	typedef struct packed {
		logic [31:0] branch_address;
		logic        taken;
	} branch_t;

	typedef struct packed {
		logic        gshare_guess;
		logic        bimodal_guess;
		logic        chose_bimodal;
		logic        final_guess;
		logic        was_correct;
		logic [31:0] correct_count;
	} result_t;

	function automatic logic [CTR_W-1:0] train2(input logic [CTR_W-1:0] c, input logic up);
		logic [CTR_W-1:0] r;
		r = c;
		if (up) begin
			if (c != CTR_STRONG_T) r = c + 2'd1;
		end else begin
			if (c != CTR_STRONG_NT) r = c - 2'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/tournament_branch_predictor_core.sv =====
`timescale 1ns / 1ps

// Tournament branch predictor (gshare + bimodal with a per-address chooser).
// Branch channel: branch_valid/branch_ready carry one resolved branch item
//   (address and actual outcome). Result channel: result_valid/result_ready
//   carry one result item per branch: both component guesses, the chooser's
//   pick, the final guess, whether it was right and the saturating hit count.
// Config channel: cfg_valid/cfg_ready write history_bits (values above 11
//   act as 11); cfg_ready is always high. Write it only while idle.
// Pipeline: an accepted branch item reads the three counter RAMs into the
//   read stage; when the read stage fires it writes them back and loads the
//   result register. Throughput: one item per cycle while the result side
//   is not stalled, set by the single read-modify-write pass through each counter
//   RAM; a write-to-read bypass covers back-to-back items that hit the same entry.
// Reset: arst_n clears control state, history and the hit count, then a
//   clearing pass writes every RAM entry, one per cycle; branch_ready stays
//   low meanwhile.
// Stall: while result_ready is low, the result register holds its item and
//   one more item can sit in the read stage; after that branch_ready drops.
module tournament_branch_predictor_core #(
	parameter int unsigned INDEX_BITS = 11
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              branch_valid,
	output logic                              branch_ready,
	input  tbp_pkg::branch_t                  branch,
	output logic                              result_valid,
	input  logic                              result_ready,
	output tbp_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tbp_pkg::HIST_CFG_W-1:0]    cfg_data
);

	localparam int unsigned DEPTH = 1 << INDEX_BITS;

	typedef logic [INDEX_BITS-1:0]         idx_t;
	typedef logic [tbp_pkg::CTR_W-1:0]     ctr_t;
	typedef logic [tbp_pkg::HIST_MAX-1:0]  hist_t;

	// Counter RAMs
	ctr_t gshare_mem  [DEPTH];
	ctr_t bimodal_mem [DEPTH];
	ctr_t chooser_mem [DEPTH];

	// Control and architectural state
	logic [tbp_pkg::HIST_CFG_W-1:0] hist_bits_q;
	hist_t                          hist_q;
	logic [31:0]                    hits_q;
	logic                           clr_busy_q;
	idx_t                           clr_idx_q;

	// Read stage
	logic  valid_s1;
	logic  taken_s1;
	idx_t  bi_s1;
	idx_t  gi_s1;
	ctr_t  g_rd_s1, b_rd_s1, c_rd_s1;
	logic  g_byp_s1, bc_byp_s1;
	ctr_t  g_byp_data_s1, b_byp_data_s1, c_byp_data_s1;

	// Result register
	logic             result_valid_q;
	tbp_pkg::result_t result_q;

	// Combinational
	logic        branch_fire, s1_fire, out_free;
	logic [3:0]  hlen;
	hist_t       hist_mask, hist_next;
	logic [31:0] gx;
	idx_t        bi_in, gi_in;
	ctr_t        g_ctr, b_ctr, c_ctr, g_new, b_new, c_new;
	logic        g_guess, b_guess, pick_b, fin_guess, g_ok, b_ok, ok;
	logic [31:0] hits_next;
	logic        wr_en;
	idx_t        wr_gi, wr_bi;
	ctr_t        wr_g, wr_b, wr_c;

	assign cfg_ready    = 1'b1;
	assign out_free     = !result_valid_q || result_ready;
	assign s1_fire      = valid_s1 && out_free;
	assign branch_ready = !clr_busy_q && (!valid_s1 || out_free);
	assign branch_fire  = branch_valid && branch_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Effective history length and mask
	always_comb begin
		hlen = (hist_bits_q > 4'(tbp_pkg::HIST_MAX)) ? 4'(tbp_pkg::HIST_MAX) : hist_bits_q;
		for (int i = 0; i < int'(tbp_pkg::HIST_MAX); i++) begin
			hist_mask[i] = (i < int'(hlen));
		end
		hist_next = {hist_q[tbp_pkg::HIST_MAX-2:0], branch.taken} & hist_mask;
	end

	// Table indexes for the incoming item; history is zero-extended or cut
	// to the index width
	assign gx    = branch.branch_address ^ 32'(hist_q);
	assign gi_in = gx[INDEX_BITS-1:0];
	assign bi_in = branch.branch_address[INDEX_BITS-1:0];

	// Predict and train on the item in the read stage
	always_comb begin
		g_ctr     = g_byp_s1  ? g_byp_data_s1 : g_rd_s1;
		b_ctr     = bc_byp_s1 ? b_byp_data_s1 : b_rd_s1;
		c_ctr     = bc_byp_s1 ? c_byp_data_s1 : c_rd_s1;
		g_guess   = g_ctr[1];
		b_guess   = b_ctr[1];
		pick_b    = c_ctr[1];
		fin_guess = pick_b ? b_guess : g_guess;
		g_ok      = (g_guess == taken_s1);
		b_ok      = (b_guess == taken_s1);
		ok        = (fin_guess == taken_s1);
		g_new     = tbp_pkg::train2(g_ctr, taken_s1);
		b_new     = tbp_pkg::train2(b_ctr, taken_s1);
		c_new     = (g_ok != b_ok) ? tbp_pkg::train2(c_ctr, b_ok) : c_ctr;
		hits_next = (ok && (hits_q != '1)) ? hits_q + 32'd1 : hits_q;
	end

	// Single write port per RAM, shared by the clearing pass and training
	always_comb begin
		wr_en = clr_busy_q || s1_fire;
		if (clr_busy_q) begin
			wr_gi = clr_idx_q;
			wr_bi = clr_idx_q;
			wr_g  = tbp_pkg::CTR_STRONG_T;
			wr_b  = tbp_pkg::CTR_STRONG_T;
			wr_c  = tbp_pkg::CHOOSE_STRONG_GSHARE;
		end else begin
			wr_gi = gi_s1;
			wr_bi = bi_s1;
			wr_g  = g_new;
			wr_b  = b_new;
			wr_c  = c_new;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			gshare_mem[wr_gi]  <= wr_g;
			bimodal_mem[wr_bi] <= wr_b;
			chooser_mem[wr_bi] <= wr_c;
		end
		if (branch_fire) begin
			g_rd_s1 <= gshare_mem[gi_in];
			b_rd_s1 <= bimodal_mem[bi_in];
			c_rd_s1 <= chooser_mem[bi_in];
		end
	end

	// Read-stage payload, bypass of the entry written at the same edge, and result register
	always_ff @(posedge clk) begin
		if (branch_fire) begin
			taken_s1      <= branch.taken;
			bi_s1         <= bi_in;
			gi_s1         <= gi_in;
			g_byp_data_s1 <= g_new;
			b_byp_data_s1 <= b_new;
			c_byp_data_s1 <= c_new;
		end
		if (s1_fire) begin
			result_q.gshare_guess  <= g_guess;
			result_q.bimodal_guess <= b_guess;
			result_q.chose_bimodal <= pick_b;
			result_q.final_guess   <= fin_guess;
			result_q.was_correct   <= ok;
			result_q.correct_count <= hits_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_bits_q    <= tbp_pkg::HIST_BITS_RESET;
			hist_q         <= '0;
			hits_q         <= '0;
			clr_busy_q     <= 1'b1;
			clr_idx_q      <= '0;
			valid_s1       <= 1'b0;
			g_byp_s1       <= 1'b0;
			bc_byp_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) hist_bits_q <= cfg_data;
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + idx_t'(1);
				if (clr_idx_q == '1) clr_busy_q <= 1'b0;
			end
			if (branch_fire) begin
				hist_q    <= hist_next;
				g_byp_s1  <= s1_fire && (gi_s1 == gi_in);
				bc_byp_s1 <= s1_fire && (bi_s1 == bi_in);
			end
			if (branch_fire) valid_s1 <= 1'b1;
			else if (s1_fire) valid_s1 <= 1'b0;
			if (s1_fire) begin
				hits_q         <= hits_next;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !branch_ready)
		else $error("branch accepted during clearing pass");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		branch_fire |=> valid_s1)
		else $error("accepted item lost before read stage");

	a_s1_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> result_valid && (result.correct_count == hits_q))
		else $error("result register not loaded from read stage");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && ok && (hits_q != '1)) |=> (hits_q == $past(hits_q) + 32'd1))
		else $error("hit count did not advance on a correct prediction");
`endif

endmodule
